// ----- rtl/mhtk_pkg.sv -----
// ----------------------------------------------------------------------------
// mhtk_pkg
// Types and constants shared by the top-k heap selector.
// ----------------------------------------------------------------------------
package mhtk_pkg;

    localparam int TAG_W   = 8;
    localparam int CNT_W   = 31;
    localparam int KEYS_W  = 2;
    localparam int TOPC_W  = 7;
    localparam int MAX_EMIT = 64;

    typedef enum logic [0:0] {
        REG_KEY_SELECT = 1'b0,
        REG_TOP_COUNT  = 1'b1
    } cfg_reg_t;

    localparam logic [KEYS_W-1:0] KEY_CONFIRMED = 2'd0;
    localparam logic [KEYS_W-1:0] KEY_DEATHS    = 2'd1;
    localparam logic [KEYS_W-1:0] KEY_RECOVERED = 2'd2;
    localparam logic [KEYS_W-1:0] KEY_RESERVED  = 2'd3;   // behaves as recovered

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_SD_RDP,
        ST_SD_RDL,
        ST_SD_RDR,
        ST_SD_CMPL,
        ST_SD_CMPR,
        ST_SD_SWAP,
        ST_POP_RD,
        ST_POP_RR,
        ST_POP_OUT,
        ST_POP_FIX
    } state_t;

endpackage

// ----- rtl/max_heap_top_k_select.sv -----
// ----------------------------------------------------------------------------
// max_heap_top_k_select
// Top-k selector: stores records, builds a binary max-heap, pops the largest.
// ----------------------------------------------------------------------------
// Records are taken one per cycle into the record memory while the block is in
// its load phase; records beyond CAPACITY are dropped. The request carrying
// tlast starts a heap build over store indices, bottom-up, keyed on the count
// chosen by key_select (3 acts as recovered), then up to top_count (capped at
// 64) pops, each giving one result request; the final one carries tlast. The
// heap and record stores are single-port synchronous memories with registered
// reads. After the last record the slot memory is filled with store indices,
// one entry a cycle. A sift-down level reads the parent slot, parent key, left
// key and right key, compares, and on a swap writes parent, then child; it
// skips the writes when it stops, and a leaf skips the key reads. The
// bottom-up build does at most about N swap levels in total. Each pop reads
// the root slot, reads the record and emits, waiting out any result stall,
// then sifts down up to log2(N) levels. No input is taken during the burst.
// No clearing pass: only entries written in the run are read.
// s_axis_tdata : record_tag[7:0], confirmed[38:8], deaths[69:39],
//                recovered[100:70], zero fill to 104 bits.
// s_axis_tlast : last_record.
module max_heap_top_k_select
    import mhtk_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [103:0]      s_axis_tdata,   // tag, confirmed, deaths, recovered
    input  logic              s_axis_tlast,   // last_record
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [103:0]      m_axis_tdata,   // out_tag, confirmed, deaths, recovered
    output logic              m_axis_tlast,   // last_out
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int NW = AW + 1;
    localparam int RW = TAG_W + 3*CNT_W;

    // record memory and heap slot memory
    logic [RW-1:0] rec_mem  [CAPACITY];
    logic [AW-1:0] slot_mem [CAPACITY];

    logic [KEYS_W-1:0] key_sel_reg;
    logic [TOPC_W-1:0] top_cnt_reg;
    state_t            state_reg, state_next;
    logic [NW-1:0]     size_reg, size_next;      // stored count, then heap size
    logic [NW-1:0]     i_reg, i_next;            // build index / init counter
    logic [NW-1:0]     at_reg, at_next;          // sift position
    logic [NW-1:0]     best_reg, best_next;
    logic [AW-1:0]     sp_reg, sp_next;          // slot at parent / popped slot
    logic [AW-1:0]     sb_reg, sb_next;          // slot at best
    logic [CNT_W-1:0]  kb_reg, kb_next;          // best key
    logic              build_reg, build_next;    // 1 while building
    logic [TOPC_W-1:0] emit_reg, emit_next;
    logic [TOPC_W-1:0] limit;

    // memory ports
    logic          r_we, s_we;
    logic [AW-1:0] r_addr, s_addr, s_wdata;
    logic [RW-1:0] r_wdata, r_rdata;
    logic [AW-1:0] s_rdata;

    always_ff @(posedge aclk) begin
        if (r_we) rec_mem[r_addr] <= r_wdata;
        r_rdata <= rec_mem[r_addr];
    end
    always_ff @(posedge aclk) begin
        if (s_we) slot_mem[s_addr] <= s_wdata;
        s_rdata <= slot_mem[s_addr];
    end

    logic [CNT_W-1:0] rd_key;
    always_comb begin
        case (key_sel_reg)
            KEY_CONFIRMED: rd_key = r_rdata[TAG_W +: CNT_W];
            KEY_DEATHS:    rd_key = r_rdata[TAG_W+CNT_W +: CNT_W];
            default:       rd_key = r_rdata[TAG_W+2*CNT_W +: CNT_W];
        endcase
    end

    assign limit = (top_cnt_reg > TOPC_W'(MAX_EMIT)) ? TOPC_W'(MAX_EMIT) : top_cnt_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_sel_reg <= '0;
            top_cnt_reg <= TOPC_W'(10);
        end else if (cfg_valid) begin
            if (cfg_index == REG_KEY_SELECT) key_sel_reg <= cfg_data[KEYS_W-1:0];
            else                             top_cnt_reg <= cfg_data[TOPC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            size_reg  <= '0;
            emit_reg  <= '0;
            build_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            size_reg  <= size_next;
            emit_reg  <= emit_next;
            build_reg <= build_next;
        end
        i_reg <= i_next; at_reg <= at_next; best_reg <= best_next;
        sp_reg <= sp_next; sb_reg <= sb_next; kb_reg <= kb_next;
    end

    logic [NW:0] lft;
    assign lft = {at_reg, 1'b1};   // 2*at+1

    always_comb begin
        state_next = state_reg; size_next = size_reg; i_next = i_reg;
        at_next = at_reg; best_next = best_reg; sp_next = sp_reg; sb_next = sb_reg;
        kb_next = kb_reg; build_next = build_reg; emit_next = emit_reg;
        r_we = 1'b0; s_we = 1'b0;
        r_addr = '0; r_wdata = s_axis_tdata[RW-1:0];
        s_addr = '0; s_wdata = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        m_axis_tlast  = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_axis_tready = 1'b1;
                r_addr = size_reg[AW-1:0];
                if (s_axis_tvalid) begin
                    if (size_reg < NW'(CAPACITY)) begin
                        r_we = 1'b1;
                        size_next = size_reg + 1'b1;
                    end
                    if (s_axis_tlast) begin
                        i_next = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                // identity fill of the slot memory, one entry a cycle
                if (i_reg < size_reg) begin
                    s_we = 1'b1; s_addr = i_reg[AW-1:0]; s_wdata = i_reg[AW-1:0];
                    i_next = i_reg + 1'b1;
                end else begin
                    i_next = size_reg >> 1;
                    build_next = 1'b1;
                    emit_next = '0;
                    if ((size_reg >> 1) != '0) begin
                        at_next = (size_reg >> 1) - 1'b1;
                        i_next  = (size_reg >> 1) - 1'b1;
                        state_next = ST_SD_RDP;
                    end else begin
                        build_next = 1'b0;
                        state_next = ST_POP_RD;
                    end
                end
            end
            ST_SD_RDP: begin
                s_addr = at_reg[AW-1:0];
                best_next = at_reg;
                if (lft >= (NW+1)'(size_reg)) state_next = ST_SD_SWAP;
                else state_next = ST_SD_RDL;
            end
            ST_SD_RDL: begin
                // slot of parent back; fetch its key, read left slot
                sp_next = s_rdata; sb_next = s_rdata;
                r_addr = s_rdata;
                s_addr = lft[AW-1:0];
                state_next = ST_SD_CMPL;
            end
            ST_SD_CMPL: begin
                kb_next = rd_key;
                r_addr = s_rdata;             // left record key
                s_addr = lft[AW-1:0] + 1'b1;  // right slot
                sb_next = s_rdata;
                state_next = ST_SD_RDR;
            end
            ST_SD_RDR: begin
                // left key vs parent key
                if (rd_key > kb_reg) begin
                    kb_next = rd_key; best_next = NW'(lft);
                end else sb_next = sp_reg;
                r_addr = s_rdata;
                s_addr = lft[AW-1:0] + 1'b1;  // keep right slot on the read port
                if ((lft + 1'b1) < (NW+1)'(size_reg)) state_next = ST_SD_CMPR;
                else state_next = ST_SD_SWAP;
            end
            ST_SD_CMPR: begin
                if (rd_key > kb_reg) begin
                    best_next = NW'(lft + 1'b1);
                    sb_next = s_rdata;
                end
                state_next = ST_SD_SWAP;
            end
            ST_SD_SWAP: begin
                if (best_reg == at_reg) begin
                    if (build_reg && i_reg != '0) begin
                        i_next = i_reg - 1'b1; at_next = i_reg - 1'b1;
                        state_next = ST_SD_RDP;
                    end else begin
                        build_next = 1'b0;
                        state_next = ST_POP_RD;
                    end
                end else begin
                    // write best slot at parent now, parent slot at best next cycle
                    s_we = 1'b1; s_addr = at_reg[AW-1:0]; s_wdata = sb_reg;
                    state_next = ST_POP_FIX;
                end
            end
            ST_POP_FIX: begin
                s_we = 1'b1; s_addr = best_reg[AW-1:0]; s_wdata = sp_reg;
                at_next = best_reg;
                state_next = ST_SD_RDP;
            end
            ST_POP_RD: begin
                if (emit_reg >= limit || size_reg == '0) begin
                    size_next = '0;
                    state_next = ST_LOAD;
                end else begin
                    s_addr = '0;
                    state_next = ST_POP_RR;
                end
            end
            ST_POP_RR: begin
                sp_next = s_rdata;               // root slot, kept for the emit
                r_addr = s_rdata;
                s_addr = AW'(size_reg - 1'b1);   // final slot
                state_next = ST_POP_OUT;
            end
            ST_POP_OUT: begin
                // both reads repeat so the request holds steady while stalled
                r_addr = sp_reg;
                s_addr = AW'(size_reg - 1'b1);
                m_axis_tvalid = 1'b1;
                m_axis_tlast  = ((emit_reg + 1'b1) >= limit) || (size_reg == NW'(1));
                if (m_axis_tready) begin
                    emit_next = emit_reg + 1'b1;
                    size_next = size_reg - 1'b1;
                    s_we = 1'b1; s_addr = '0; s_wdata = s_rdata;
                    at_next = '0;
                    state_next = (size_reg == NW'(1)) ? ST_POP_RD : ST_SD_RDP;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    assign m_axis_tdata = {{(104-RW){1'b0}}, r_rdata};

    a_no_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> !s_axis_tready) else $error("input taken in burst");
    a_size_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        size_reg <= NW'(CAPACITY)) else $error("store overfilled");
    a_emit_lim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (emit_reg < limit)) else $error("too many results");

endmodule
